>>> design/ctak_pkg.sv
`default_nettype none

package ctak_pkg;

    localparam int CHAN_W        = 8;
    localparam int KEY_W         = 24;
    localparam int NUM_CHAN      = 3;
    localparam int FRAC_BITS     = 12;
    localparam int QUO_W         = FRAC_BITS + 1;
    localparam int DARK_SHIFT    = 4;
    localparam int KEY_LOW_LIMIT = 2;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS;

    // Prep stage, divider stages, max stage, multiply stage
    localparam int PIPE_DEPTH = DIV_STAGES + 3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pix_t;

    // Per-channel divider state
    typedef struct packed {
        logic              dark;
        logic [CHAN_W-1:0] div;
        logic [CHAN_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } chan_t;

    typedef struct packed {
        pix_t                       pix;
        chan_t [NUM_CHAN-1:0]       ch;
    } stage_t;

    // Set up the division for one channel; the leading quotient bit is
    // resolved here since the difference never exceeds the divisor.
    function automatic chan_t chan_prep(input logic [CHAN_W-1:0] key,
                                        input logic [CHAN_W-1:0] v);
        chan_t             c;
        logic [CHAN_W-1:0] diff;
        logic              full;
        if (key < CHAN_W'(KEY_LOW_LIMIT)) begin
            c.dark = 1'b1;
            c.div  = CHAN_W'(1);
            diff   = '0;
        end
        else if (v > key) begin
            c.dark = 1'b0;
            c.div  = CHAN_FULL - key;
            diff   = v - key;
        end
        else begin
            c.dark = 1'b0;
            c.div  = key;
            diff   = key - v;
        end
        full  = (diff == c.div);
        c.quo = QUO_W'(full);
        c.rem = full ? '0 : diff;
        return c;
    endfunction

    // One restoring division step: shift in a zero, subtract if it fits
    function automatic chan_t div_step(input chan_t c);
        chan_t           n;
        logic [CHAN_W:0] shifted;
        n       = c;
        shifted = {c.rem, 1'b0};
        if (shifted >= {1'b0, c.div}) begin
            n.rem = CHAN_W'(shifted - {1'b0, c.div});
            n.quo = {c.quo[QUO_W-2:0], 1'b1};
        end
        else begin
            n.rem = shifted[CHAN_W-1:0];
            n.quo = {c.quo[QUO_W-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> design/ctak_if.sv
`default_nettype none

interface ctak_in_if;
    logic                        valid;
    logic                        ready;
    logic [ctak_pkg::CHAN_W-1:0] in_red;
    logic [ctak_pkg::CHAN_W-1:0] in_green;
    logic [ctak_pkg::CHAN_W-1:0] in_blue;
    logic [ctak_pkg::CHAN_W-1:0] in_alpha;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output in_alpha, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    input in_alpha, output ready);
endinterface

interface ctak_out_if;
    logic                        valid;
    logic                        ready;
    logic [ctak_pkg::CHAN_W-1:0] out_red;
    logic [ctak_pkg::CHAN_W-1:0] out_green;
    logic [ctak_pkg::CHAN_W-1:0] out_blue;
    logic [ctak_pkg::CHAN_W-1:0] out_alpha;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, output ready);
endinterface

`default_nettype wire

>>> design/ctak_prep.sv
`default_nettype none

module ctak_prep (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [ctak_pkg::KEY_W-1:0] key,
    input  wire logic                       up_valid,
    input  wire ctak_pkg::pix_t             up_pix,
    output logic                            up_ready,
    output logic                            dn_valid,
    output ctak_pkg::stage_t                dn_data,
    input  wire logic                       dn_ready
);

    logic             valid_reg;
    ctak_pkg::stage_t data_reg;
    ctak_pkg::stage_t data_next;

    // Advance when empty or when the next stage takes the request
    assign up_ready = !valid_reg || dn_ready;

    // Split the key and set up one division per channel
    always_comb
    begin
        data_next.pix   = up_pix;
        data_next.ch[0] = ctak_pkg::chan_prep(key[23:16], up_pix.red);
        data_next.ch[1] = ctak_pkg::chan_prep(key[15:8],  up_pix.green);
        data_next.ch[2] = ctak_pkg::chan_prep(key[7:0],   up_pix.blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

>>> design/ctak_div_stage.sv
`default_nettype none

module ctak_div_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    input  wire ctak_pkg::stage_t up_data,
    output logic                  up_ready,
    output logic                  dn_valid,
    output ctak_pkg::stage_t      dn_data,
    input  wire logic             dn_ready
);

    logic             valid_reg;
    ctak_pkg::stage_t data_reg;
    ctak_pkg::stage_t data_next;

    assign up_ready = !valid_reg || dn_ready;

    // Resolve a few quotient bits on all three channels side by side
    always_comb
    begin
        data_next = up_data;
        for (int c = 0; c < ctak_pkg::NUM_CHAN; c++)
        begin
            for (int s = 0; s < ctak_pkg::DIV_STEPS; s++)
            begin
                data_next.ch[c] = ctak_pkg::div_step(data_next.ch[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

>>> design/ctak_alpha.sv
`default_nettype none

module ctak_alpha (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    input  wire ctak_pkg::stage_t up_data,
    output logic                  up_ready,
    output logic                  dn_valid,
    output ctak_pkg::pix_t        dn_pix,
    input  wire logic             dn_ready
);

    localparam int PROD_W = ctak_pkg::QUO_W + ctak_pkg::CHAN_W;
    localparam int SCL_W  = PROD_W - ctak_pkg::FRAC_BITS;

    logic                         max_valid_reg;
    ctak_pkg::pix_t               max_pix_reg;
    logic [ctak_pkg::QUO_W-1:0]   max_dist_reg;
    logic [ctak_pkg::QUO_W-1:0]   max_dist_next;
    logic                         out_valid_reg;
    ctak_pkg::pix_t               out_pix_reg;
    ctak_pkg::pix_t               out_pix_next;
    logic                         max_en;
    logic                         out_en;

    logic [ctak_pkg::CHAN_W-1:0]  chan_val  [ctak_pkg::NUM_CHAN];
    logic [ctak_pkg::QUO_W-1:0]   chan_dist [ctak_pkg::NUM_CHAN];
    logic [PROD_W-1:0]            prod;
    logic [SCL_W-1:0]             scaled;

    // Stall chain: each stage moves when empty or when downstream moves
    assign out_en   = !out_valid_reg || dn_ready;
    assign max_en   = !max_valid_reg || out_en;
    assign up_ready = max_en;

    // Pick per-channel distance, take the largest, never let it be zero
    always_comb
    begin
        chan_val[0] = up_data.pix.red;
        chan_val[1] = up_data.pix.green;
        chan_val[2] = up_data.pix.blue;
        for (int c = 0; c < ctak_pkg::NUM_CHAN; c++)
        begin
            if (up_data.ch[c].dark)
            begin
                chan_dist[c] = ctak_pkg::QUO_W'({chan_val[c],
                                                 ctak_pkg::DARK_SHIFT'(0)});
            end
            else
            begin
                chan_dist[c] = up_data.ch[c].quo;
            end
        end
        max_dist_next = chan_dist[0];
        for (int c = 1; c < ctak_pkg::NUM_CHAN; c++)
        begin
            if (chan_dist[c] > max_dist_next)
            begin
                max_dist_next = chan_dist[c];
            end
        end
        if (max_dist_next == '0)
        begin
            max_dist_next = ctak_pkg::QUO_W'(1);
        end
    end

    // Scale the old alpha and clamp
    always_comb
    begin
        prod         = PROD_W'(max_dist_reg) * PROD_W'(max_pix_reg.alpha);
        scaled       = prod[PROD_W-1:ctak_pkg::FRAC_BITS];
        out_pix_next = max_pix_reg;
        if (scaled > SCL_W'(ctak_pkg::CHAN_FULL))
        begin
            out_pix_next.alpha = ctak_pkg::CHAN_FULL;
        end
        else
        begin
            out_pix_next.alpha = scaled[ctak_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (max_en)
            begin
                max_valid_reg <= up_valid;
            end
            if (out_en)
            begin
                out_valid_reg <= max_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (max_en && up_valid)
        begin
            max_pix_reg  <= up_data.pix;
            max_dist_reg <= max_dist_next;
        end
        if (out_en && max_valid_reg)
        begin
            out_pix_reg <= out_pix_next;
        end
    end

    assign dn_valid = out_valid_reg;
    assign dn_pix   = out_pix_reg;

endmodule

`default_nettype wire

>>> design/color_to_alpha_keyer_unit.sv
// Throughput: one pixel per cycle while the output is not stalled; the
// six register stages (prep, three divider stages of four quotient bits
// each, max select, multiply) each hold one pixel and move independently,
// so bubbles close up under stall.
// Reset: rst_n clears all stage valid bits and sets the key color to zero.
`default_nettype none

module color_to_alpha_keyer_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [ctak_pkg::KEY_W-1:0] cfg_wr_data,
    ctak_in_if.sink                         pixel,
    ctak_out_if.source                      keyed
);

    logic [ctak_pkg::KEY_W-1:0] key_color_reg;

    ctak_pkg::pix_t             in_pix;
    ctak_pkg::pix_t             res_pix;
    logic [ctak_pkg::DIV_STAGES:0] chain_valid;
    logic [ctak_pkg::DIV_STAGES:0] chain_ready;
    ctak_pkg::stage_t           chain_data [ctak_pkg::DIV_STAGES+1];

    // Hold the key color
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_color_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            key_color_reg <= cfg_wr_data;
        end
    end

    assign in_pix.red   = pixel.in_red;
    assign in_pix.green = pixel.in_green;
    assign in_pix.blue  = pixel.in_blue;
    assign in_pix.alpha = pixel.in_alpha;

    ctak_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key_color_reg),
        .up_valid (pixel.valid),
        .up_pix   (in_pix),
        .up_ready (pixel.ready),
        .dn_valid (chain_valid[0]),
        .dn_data  (chain_data[0]),
        .dn_ready (chain_ready[0])
    );

    // Divider pipeline
    for (genvar g = 0; g < ctak_pkg::DIV_STAGES; g++)
    begin : g_div
        ctak_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_data  (chain_data[g]),
            .up_ready (chain_ready[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_data  (chain_data[g+1]),
            .dn_ready (chain_ready[g+1])
        );
    end

    ctak_alpha u_alpha (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[ctak_pkg::DIV_STAGES]),
        .up_data  (chain_data[ctak_pkg::DIV_STAGES]),
        .up_ready (chain_ready[ctak_pkg::DIV_STAGES]),
        .dn_valid (keyed.valid),
        .dn_pix   (res_pix),
        .dn_ready (keyed.ready)
    );

    assign keyed.out_red   = res_pix.red;
    assign keyed.out_green = res_pix.green;
    assign keyed.out_blue  = res_pix.blue;
    assign keyed.out_alpha = res_pix.alpha;

endmodule

`default_nettype wire

>>> design/ctak_checker.sv
`default_nettype none

module ctak_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [ctak_pkg::CHAN_W-1:0] out_red,
    input wire logic [ctak_pkg::CHAN_W-1:0] out_green,
    input wire logic [ctak_pkg::CHAN_W-1:0] out_blue,
    input wire logic [ctak_pkg::CHAN_W-1:0] out_alpha
);

    localparam int CNT_W = $clog2(ctak_pkg::PIPE_DEPTH + 1);

    logic [CNT_W-1:0] in_flight_reg;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Track requests taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            in_flight_reg <= in_flight_reg + CNT_W'(1);
        end
        else if (out_acc && !in_acc)
        begin
            in_flight_reg <= in_flight_reg - CNT_W'(1);
        end
    end

    // A result never appears without a request behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_flight_reg != '0)
        else $error("result shown with nothing in flight");

    // Never hold more requests than there are stages
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= CNT_W'(ctak_pkg::PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    // An empty pipeline always takes a request
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg == '0 |-> in_ready)
        else $error("empty pipeline refuses a request");

    // A stalled result stays and keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red)
            && $stable(out_green) && $stable(out_blue) && $stable(out_alpha))
        else $error("stalled result dropped or changed");

endmodule

bind color_to_alpha_keyer_unit ctak_checker u_ctak_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (keyed.valid),
    .out_ready (keyed.ready),
    .out_red   (keyed.out_red),
    .out_green (keyed.out_green),
    .out_blue  (keyed.out_blue),
    .out_alpha (keyed.out_alpha)
);

`default_nettype wire

>>> bench/tb_color_to_alpha_keyer_unit.sv
`timescale 1ns / 1ps

module tb_color_to_alpha_keyer_unit;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } stall_mode_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [ctak_pkg::KEY_W-1:0]   cfg_wr_data;

    ctak_in_if  pixel_bus ();
    ctak_out_if keyed_bus ();

    // Key color as last written, and pixels waiting to come out keyed
    logic [ctak_pkg::KEY_W-1:0]   key_setting;
    ctak_pkg::pix_t               expected_pixels[$];
    int unsigned                  burst_left;
    int unsigned                  error_count;

    color_to_alpha_keyer_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pixel       (pixel_bus),
        .keyed       (keyed_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Distance of one channel from its key channel, 4096 meaning full distance
    function automatic int unsigned key_distance(
        input logic [ctak_pkg::CHAN_W-1:0] key_chan,
        input logic [ctak_pkg::CHAN_W-1:0] value);
        int unsigned k;
        int unsigned v;
        k = 32'(key_chan);
        v = 32'(value);
        if (k < ctak_pkg::KEY_LOW_LIMIT)
            return v << ctak_pkg::DARK_SHIFT;
        if (v > k)
            return ((v - k) << ctak_pkg::FRAC_BITS) / (int'(ctak_pkg::CHAN_FULL) - k);
        return ((k - v) << ctak_pkg::FRAC_BITS) / k;
    endfunction

    // Pass the color through and scale alpha by the largest channel distance
    function automatic ctak_pkg::pix_t keyed_pixel(input logic [ctak_pkg::KEY_W-1:0] key,
                                                   input ctak_pkg::pix_t p);
        ctak_pkg::pix_t res;
        int unsigned    max_dist;
        int unsigned    chan_dist;
        int unsigned    new_alpha;
        max_dist  = key_distance(key[23:16], p.red);
        chan_dist = key_distance(key[15:8], p.green);
        if (chan_dist > max_dist)
            max_dist = chan_dist;
        chan_dist = key_distance(key[7:0], p.blue);
        if (chan_dist > max_dist)
            max_dist = chan_dist;
        if (max_dist == 0)
            max_dist = 1;
        new_alpha = (max_dist * 32'(p.alpha)) >> ctak_pkg::FRAC_BITS;
        if (new_alpha > int'(ctak_pkg::CHAN_FULL))
            new_alpha = 32'(ctak_pkg::CHAN_FULL);
        res       = p;
        res.alpha = new_alpha[ctak_pkg::CHAN_W-1:0];
        return res;
    endfunction

    function automatic ctak_pkg::pix_t make_pixel(input logic [ctak_pkg::CHAN_W-1:0] r,
                                                  input logic [ctak_pkg::CHAN_W-1:0] g,
                                                  input logic [ctak_pkg::CHAN_W-1:0] b,
                                                  input logic [ctak_pkg::CHAN_W-1:0] a);
        ctak_pkg::pix_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.alpha = a;
        return p;
    endfunction

    // Channel value biased toward the key channel and the range ends
    function automatic logic [ctak_pkg::CHAN_W-1:0] channel_near(
        input logic [ctak_pkg::CHAN_W-1:0] key_chan);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? ctak_pkg::CHAN_FULL : '0;
            1:       return key_chan;
            2:       return key_chan + ctak_pkg::CHAN_W'($urandom_range(0, 6))
                            - ctak_pkg::CHAN_W'(3);
            default: return ctak_pkg::CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Key channel biased toward the dark limit and the top of the range
    function automatic logic [ctak_pkg::CHAN_W-1:0] key_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ctak_pkg::CHAN_W'(1);
            2:       return ctak_pkg::CHAN_W'(ctak_pkg::KEY_LOW_LIMIT);
            3:       return ctak_pkg::CHAN_FULL - ctak_pkg::CHAN_W'(1);
            4:       return ctak_pkg::CHAN_FULL;
            default: return ctak_pkg::CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [ctak_pkg::CHAN_W-1:0] random_alpha();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return ctak_pkg::CHAN_FULL;
            default: return ctak_pkg::CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one request, idling between bursts
    task automatic send_pixel(input ctak_pkg::pix_t p);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                pixel_bus.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        pixel_bus.valid    <= 1'b1;
        pixel_bus.in_red   <= p.red;
        pixel_bus.in_green <= p.green;
        pixel_bus.in_blue  <= p.blue;
        pixel_bus.in_alpha <= p.alpha;
        @(posedge clk);
        while (!pixel_bus.ready)
            @(posedge clk);
        expected_pixels.push_back(keyed_pixel(key_setting, p));
    endtask

    // Drop valid, wait for every pending result, then let the pipeline settle
    task automatic drain_keyer();
        @(negedge clk);
        pixel_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (ctak_pkg::PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_key(input logic [ctak_pkg::KEY_W-1:0] key);
        drain_keyer();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= key;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        key_setting = key;
    endtask

    // Key color from reset is black: every channel uses the dark rule
    task automatic test_reset_key();
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd1, 8'd1, 8'd1, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd128));
    endtask

    // Pixel equal to the key: distance forced to one, alpha goes to zero; also a pixel one step off the key
    task automatic test_key_match();
        write_key(24'h8040C0);
        send_pixel(make_pixel(8'h80, 8'h40, 8'hC0, 8'd255));
        send_pixel(make_pixel(8'h80, 8'h40, 8'hC0, 8'h80));
        send_pixel(make_pixel(8'h81, 8'h40, 8'hC0, 8'd255));
    endtask

    // Key channels of zero and one skip the division
    task automatic test_dark_key();
        write_key(24'h010001);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd128, 8'd1, 8'd255));
        send_pixel(make_pixel(8'd16, 8'd0, 8'd255, 8'd200));
    endtask

    // Smallest and largest divisors on both sides of the key
    task automatic test_divisor_extremes();
        write_key(24'hFFFFFF);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd254, 8'd255, 8'd255, 8'd255));
        write_key(24'h02FE02);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd0, 8'd254, 8'd2, 8'd255));
        write_key(24'hFEFEFE);
        send_pixel(make_pixel(8'd255, 8'd0, 8'd254, 8'd255));
        send_pixel(make_pixel(8'd253, 8'd255, 8'd254, 8'd1));
    endtask

    // Random pixels over a series of key colors, the range ends among them
    task automatic test_random_stream();
        logic [ctak_pkg::KEY_W-1:0] key;
        ctak_pkg::pix_t             p;
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 0)
                key = '0;
            else if (phase == 1)
                key = {ctak_pkg::KEY_W{1'b1}};
            else
                key = {key_channel(), key_channel(), key_channel()};
            write_key(key);
            for (int n = 0; n < 100; n++)
            begin
                p = make_pixel(channel_near(key[23:16]), channel_near(key[15:8]),
                               channel_near(key[7:0]), random_alpha());
                send_pixel(p);
                // hold off mid-phase until the pipeline is empty
                if (phase == 4 && n == 50)
                    drain_keyer();
            end
        end
    endtask

    task automatic check_field(input string name,
                               input logic [ctak_pkg::CHAN_W-1:0] expected,
                               input logic [ctak_pkg::CHAN_W-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            error_count++;
        end
    endtask

    // Compare each accepted result with the oldest pending pixel
    initial
    begin
        ctak_pkg::pix_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && keyed_bus.valid && keyed_bus.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result with no pending request: alpha %0d", keyed_bus.out_alpha);
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("out_red", want.red, keyed_bus.out_red);
                    check_field("out_green", want.green, keyed_bus.out_green);
                    check_field("out_blue", want.blue, keyed_bus.out_blue);
                    check_field("out_alpha", want.alpha, keyed_bus.out_alpha);
                end
            end
        end
    end

    // Output stall pattern: free running, random stalls, or stall runs
    initial
    begin
        stall_mode_t mode;
        int unsigned span;
        int unsigned hold;
        keyed_bus.ready = 1'b0;
        mode = STALL_NONE;
        span = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 2));
                span = $urandom_range(16, 96);
            end
            span--;
            case (mode)
                STALL_NONE:
                    keyed_bus.ready <= 1'b1;
                STALL_RANDOM:
                    keyed_bus.ready <= ($urandom_range(0, 2) != 0);
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        keyed_bus.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 5) == 0)
                    begin
                        hold = $urandom_range(0, 7);
                        keyed_bus.ready <= 1'b0;
                    end
                    else
                        keyed_bus.ready <= 1'b1;
                end
            endcase
        end
    end

    initial
    begin
        #2_000_000;
        $display("color_to_alpha_keyer_unit test failed");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        pixel_bus.valid    = 1'b0;
        pixel_bus.in_red   = '0;
        pixel_bus.in_green = '0;
        pixel_bus.in_blue  = '0;
        pixel_bus.in_alpha = '0;
        key_setting        = '0;
        burst_left         = 0;
        error_count        = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_key();
        test_key_match();
        test_dark_key();
        test_divisor_extremes();
        test_random_stream();

        drain_keyer();
        if (error_count == 0)
            $display("color_to_alpha_keyer_unit test passed");
        else
            $display("color_to_alpha_keyer_unit test failed");
        $finish;
    end

endmodule
